FILE: src/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg: shared definitions for the lid tilt confirmation machine
// Field widths, state and status codes, and the transition table.
// ----------------------------------------------------------------------------
package ltc_pkg;

   localparam int EventStatusW = 3;
   localparam int OutStatusW   = 2;
   localparam int StateW       = 3;
   localparam int TimeW        = 32;

   localparam logic [TimeW-1:0] ConfirmTimeReset = 32'd2500;

   // qualifier states, numbered in table order
   localparam logic [StateW-1:0] ST_CREATED      = 3'd0;
   localparam logic [StateW-1:0] ST_NEW_CLOSE    = 3'd1;
   localparam logic [StateW-1:0] ST_VERIFY_CLOSE = 3'd2;
   localparam logic [StateW-1:0] ST_CONF_CLOSE   = 3'd3;
   localparam logic [StateW-1:0] ST_NEW_OPEN     = 3'd4;
   localparam logic [StateW-1:0] ST_VERIFY_OPEN  = 3'd5;
   localparam logic [StateW-1:0] ST_CONF_OPEN    = 3'd6;
   localparam logic [StateW-1:0] ST_LOST         = 3'd7;

   // forwarded status codes
   localparam logic [OutStatusW-1:0] STAT_LEVEL  = 2'd0;
   localparam logic [OutStatusW-1:0] STAT_RAISED = 2'd1;
   localparam logic [OutStatusW-1:0] STAT_LOST   = 2'd2;
   localparam logic [OutStatusW-1:0] STAT_PING   = 2'd3;

   // highest event status that is forwarded; anything above is dropped
   localparam logic [EventStatusW-1:0] EventStatusMax = 3'd3;

   typedef struct packed {
      logic              move;
      logic [StateW-1:0] state;
   } next_type;

   function automatic next_type next_lookup(input logic [StateW-1:0]     cur,
                                            input logic [OutStatusW-1:0] stat);
      next_type nx;
      nx.move  = 1'b1;
      nx.state = cur;
      case (stat)
         STAT_LEVEL: begin
            case (cur)
               ST_CREATED:                    nx.state = ST_NEW_CLOSE;
               ST_NEW_CLOSE, ST_VERIFY_CLOSE: nx.state = ST_VERIFY_CLOSE;
               ST_CONF_CLOSE:                 nx.move  = 1'b0;
               default:                       nx.state = ST_NEW_CLOSE;
            endcase
         end
         STAT_RAISED: begin
            case (cur)
               ST_CREATED, ST_VERIFY_CLOSE, ST_CONF_CLOSE, ST_LOST:
                  nx.state = ST_NEW_OPEN;
               default:
                  nx.state = ST_VERIFY_OPEN;
            endcase
         end
         STAT_LOST: begin
            if (cur == ST_LOST) begin
               nx.move = 1'b0;
            end else begin
               nx.state = ST_LOST;
            end
         end
         default: begin
            // ping
            case (cur)
               ST_NEW_CLOSE, ST_VERIFY_CLOSE:              nx.state = ST_VERIFY_CLOSE;
               ST_NEW_OPEN, ST_VERIFY_OPEN:                nx.state = ST_VERIFY_OPEN;
               default:                                    nx.move  = 1'b0;
            endcase
         end
      endcase
      return nx;
   endfunction

endpackage

FILE: src/lid_tilt_confirmation_fsm.sv
// ----------------------------------------------------------------------------
// lid_tilt_confirmation_fsm: lid tilt confirmation state machine
// Qualifies tilt events over time and forwards a status word per event of status 3 or below.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | event_status, now_ms
//  rsp     | out       | rsp_valid/stall    | out_status, out_state
//  csr     | in        | csr_valid/ready    | confirm_time_ms
//
// One word per cycle sustained while rsp is not stalled; each word passes
// the input register, then the result register. The table lookup and one 32-bit
// subtract-compare sit between the two registers.
// Reset: state created, stamp 0, confirm time 2500 ms, both registers empty.
// Words with status above 3 are consumed and give no rsp word.
// req_stall rises only while both registers are full and rsp is stalled.
module lid_tilt_confirmation_fsm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ltc_pkg::EventStatusW-1:0]    req_event_status,
   input  logic [ltc_pkg::TimeW-1:0]           req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ltc_pkg::OutStatusW-1:0]      rsp_out_status,
   output logic [ltc_pkg::StateW-1:0]          rsp_out_state,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ltc_pkg::TimeW-1:0]           csr_confirm_time_ms
);
   import ltc_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [EventStatusW-1:0] in_status_ff;
   logic [TimeW-1:0]        in_now_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [OutStatusW-1:0]   out_status_ff, out_status_in;
   logic [StateW-1:0]       out_state_ff;
   logic [StateW-1:0]       state_ff, state_in;
   logic [TimeW-1:0]        stamp_ff, stamp_in;
   logic [TimeW-1:0]        confirm_ff;
   logic                    req_take, fire, word_ok, elapsed_done;
   logic [TimeW-1:0]        elapsed;
   next_type                nx;

   assign csr_ready = 1'b1;

   assign req_stall = in_valid_ff & out_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign fire      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign word_ok   = in_status_ff <= EventStatusMax;

   assign nx           = next_lookup(state_ff, in_status_ff[OutStatusW-1:0]);
   assign elapsed      = in_now_ff - stamp_ff;
   assign elapsed_done = elapsed >= confirm_ff;

   always_comb begin
      state_in      = state_ff;
      stamp_in      = stamp_ff;
      out_status_in = in_status_ff[OutStatusW-1:0];
      if (nx.move) begin
         state_in = nx.state;
         case (nx.state)
            ST_NEW_CLOSE: begin
               stamp_in      = in_now_ff;
               out_status_in = STAT_PING;
            end
            ST_NEW_OPEN: begin
               stamp_in = in_now_ff;
            end
            ST_VERIFY_CLOSE: begin
               if (elapsed_done) begin
                  state_in = ST_CONF_CLOSE;
               end else begin
                  out_status_in = STAT_PING;
               end
            end
            ST_VERIFY_OPEN: begin
               if (elapsed_done) begin
                  state_in = ST_CONF_OPEN;
               end else begin
                  out_status_in = STAT_PING;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = word_ok;
      end else if (out_valid_ff & ~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_CREATED;
         stamp_ff     <= '0;
         confirm_ff   <= ConfirmTimeReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire & word_ok) begin
            state_ff <= state_in;
            stamp_ff <= stamp_in;
         end
         if (csr_valid & csr_ready) begin
            confirm_ff <= csr_confirm_time_ms;
         end
      end
   end

   // payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_status_ff <= req_event_status;
         in_now_ff    <= req_now_ms;
      end
      if (fire & word_ok) begin
         out_status_ff <= out_status_in;
         out_state_ff  <= state_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_status = out_status_ff;
   assign rsp_out_state  = out_state_ff;

endmodule

FILE: src/ltc_checker.sv
// ----------------------------------------------------------------------------
// ltc_checker: port-level checks for the lid tilt confirmation machine
// Watches the top level's ports and flags protocol and qualifier slips.
// ----------------------------------------------------------------------------
module ltc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [ltc_pkg::EventStatusW-1:0]    req_event_status,
   input logic [ltc_pkg::TimeW-1:0]           req_now_ms,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ltc_pkg::OutStatusW-1:0]      rsp_out_status,
   input logic [ltc_pkg::StateW-1:0]          rsp_out_state
);
   import ltc_pkg::*;

   // a stalled req word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_event_status)
                                 && $stable(req_now_ms))
      else $error("req word changed while stalled");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_status)
                                 && $stable(rsp_out_state))
      else $error("rsp word changed while stalled");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // a fresh closure is never forwarded as a real status
   a_new_close_ping: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_state == ST_NEW_CLOSE |-> rsp_out_status == STAT_PING)
      else $error("new closure forwarded a real status");

   // unconfirmed verifying states forward ping only
   a_verify_ping: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_state == ST_VERIFY_CLOSE || rsp_out_state == ST_VERIFY_OPEN)
      |-> rsp_out_status == STAT_PING)
      else $error("verifying state forwarded a real status");

endmodule

bind lid_tilt_confirmation_fsm ltc_checker u_ltc_checker (.*);
